[src/s2cd_pkg.sv]
// ----------------------------------------------------------------------------
// s2cd_pkg
// Shared types and constants for the epoch-seconds to calendar converter.
// ----------------------------------------------------------------------------
package s2cd_pkg;

  localparam logic [11:0] EPOCH_YEAR = 12'd1970;
  localparam logic [2:0]  EPOCH_WDAY = 3'd4;      // 1970-01-01 was a Thursday

  // divisor select for the shared constant divider
  localparam logic [1:0] DIV_DAY  = 2'd0;
  localparam logic [1:0] DIV_HOUR = 2'd1;
  localparam logic [1:0] DIV_MIN  = 2'd2;
  localparam logic [1:0] DIV_WEEK = 2'd3;

  // reciprocals, exact over each operand range:
  //   day : (secs >> 7) * RECIP_DAY  >> 35  = secs / 86400  (25-bit operand)
  //   hour: (tod  >> 4) * RECIP_HOUR >> 21  = tod  / 3600   (13-bit operand)
  //   min : (hrem >> 2) * RECIP_MIN  >> 14  = hrem / 60     (10-bit operand)
  //   week: v           * RECIP_WEEK >> 12  = v    / 7      (9-bit operand)
  localparam logic [25:0] RECIP_DAY  = 26'd50903317;
  localparam logic [25:0] RECIP_HOUR = 26'd9321;
  localparam logic [25:0] RECIP_MIN  = 26'd1093;
  localparam logic [25:0] RECIP_WEEK = 26'd586;

  typedef struct packed {
    logic       load;        // capture a new input word
    logic       div_quo;     // quotient by reciprocal multiply
    logic       div_rem;     // remainder: operand minus quotient * divisor
    logic [1:0] div_sel;
    logic       year_step;   // subtract one year length
    logic       month_step;  // probe one month boundary
    logic       out_load;    // copy results into the output register
  } cmd_t;

  typedef struct packed {
    logic year_done;   // days left fit inside the current year
    logic month_hit;   // days left fall before the probed boundary
  } sts_t;

  function automatic logic [16:0] div_base(input logic [1:0] sel);
    logic [16:0] b;
    case (sel)
      DIV_DAY:  b = 17'd86400;
      DIV_HOUR: b = 17'd3600;
      DIV_MIN:  b = 17'd60;
      DIV_WEEK: b = 17'd7;
      default:  b = 17'd7;
    endcase
    return b;
  endfunction

  // days before month idx (idx 0..12), leap day added from March on
  function automatic logic [8:0] days_before(input logic leap, input logic [3:0] idx);
    logic [8:0] d;
    case (idx)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      4'd12:   d = 9'd365;
      default: d = 9'd365;
    endcase
    if (leap && (idx >= 4'd2)) begin
      d = d + 9'd1;
    end
    return d;
  endfunction

endpackage

[src/seconds_to_calendar_date.sv]
// ----------------------------------------------------------------------------
// seconds_to_calendar_date
// Unix epoch seconds to Gregorian date, time of day and weekday.
// ----------------------------------------------------------------------------
// Takes one 32-bit word of seconds since 1970-01-01 00:00:00 and returns one
// word with year (1970..2106), month, day of month, hour, minute, second and
// weekday (0 = Sunday). One word is in flight at a time; in_ready is high only
// while the sequencer is idle. Conversion takes longer for later years and
// months, plus any wait for the output register to free up; the next word
// can be accepted the cycle after the result loads. The year walk subtracts
// one year length per cycle and the month probe checks one table boundary
// per cycle; the rest is a shared constant divider that does each division
// as a reciprocal multiply for the quotient, then a multiply-subtract for
// the remainder, for days, hours, minutes and the weekday modulo 7. The
// finished word sits in an output register, so it may wait on out_ready
// while the next input word is accepted and converted.
// ----------------------------------------------------------------------------
module seconds_to_calendar_date (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_epoch_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day_of_month,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second,
  output logic [2:0]  out_weekday
);

  s2cd_pkg::cmd_t cmd;
  s2cd_pkg::sts_t sts;

  // sequencer: states, quotient/remainder phase, handshakes
  s2cd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: divider, calendar walk, output register
  s2cd_dp u_dp (
    .clk              (clk),
    .cmd              (cmd),
    .sts              (sts),
    .in_epoch_seconds (in_epoch_seconds),
    .out_year         (out_year),
    .out_month        (out_month),
    .out_day_of_month (out_day_of_month),
    .out_hour         (out_hour),
    .out_minute       (out_minute),
    .out_second       (out_second),
    .out_weekday      (out_weekday)
  );

endmodule

[src/s2cd_dp.sv]
// ----------------------------------------------------------------------------
// s2cd_dp
// Datapath: shared constant divider, year/month walk, weekday tracking,
// output word.
// ----------------------------------------------------------------------------
module s2cd_dp (
  input  logic             clk,
  input  s2cd_pkg::cmd_t   cmd,
  output s2cd_pkg::sts_t   sts,
  input  logic [31:0]      in_epoch_seconds,
  output logic [11:0]      out_year,
  output logic [3:0]       out_month,
  output logic [4:0]       out_day_of_month,
  output logic [4:0]       out_hour,
  output logic [5:0]       out_minute,
  output logic [5:0]       out_second,
  output logic [2:0]       out_weekday
);

  logic [31:0] rem_r;
  logic [15:0] quo_r;
  logic [15:0] left_r;     // whole days not yet assigned
  logic [11:0] year_r;
  logic [1:0]  m4_r;
  logic [6:0]  m100_r;
  logic [8:0]  m400_r;
  logic [2:0]  wacc_r;     // weekday of Jan 1 of year_r
  logic [3:0]  mon_r;
  logic [4:0]  mday_r;
  logic [4:0]  hour_r;
  logic [5:0]  min_r;
  logic [5:0]  sec_r;
  logic [2:0]  wday_r;

  logic [24:0] mul_a;
  logic [25:0] mul_b;
  logic [50:0] prod;
  logic [15:0] quo_nxt;
  logic [32:0] qb;
  logic [31:0] rem_nxt;
  logic        leap;
  logic [8:0]  ylen;
  logic [3:0]  wsum;
  logic [2:0]  wacc_nxt;
  logic [8:0]  bound;
  logic [8:0]  prev;

  // operand pre-shift and reciprocal per divisor
  always_comb begin
    case (cmd.div_sel)
      s2cd_pkg::DIV_DAY: begin
        mul_a = rem_r[31:7];
        mul_b = s2cd_pkg::RECIP_DAY;
      end
      s2cd_pkg::DIV_HOUR: begin
        mul_a = {12'd0, rem_r[16:4]};
        mul_b = s2cd_pkg::RECIP_HOUR;
      end
      s2cd_pkg::DIV_MIN: begin
        mul_a = {15'd0, rem_r[11:2]};
        mul_b = s2cd_pkg::RECIP_MIN;
      end
      s2cd_pkg::DIV_WEEK: begin
        mul_a = {16'd0, rem_r[8:0]};
        mul_b = s2cd_pkg::RECIP_WEEK;
      end
      default: begin
        mul_a = {16'd0, rem_r[8:0]};
        mul_b = s2cd_pkg::RECIP_WEEK;
      end
    endcase
  end

  assign prod = 51'(mul_a) * 51'(mul_b);

  always_comb begin
    case (cmd.div_sel)
      s2cd_pkg::DIV_DAY:  quo_nxt = prod[50:35];
      s2cd_pkg::DIV_HOUR: quo_nxt = {11'd0, prod[25:21]};
      s2cd_pkg::DIV_MIN:  quo_nxt = {10'd0, prod[19:14]};
      s2cd_pkg::DIV_WEEK: quo_nxt = {10'd0, prod[17:12]};
      default:            quo_nxt = {10'd0, prod[17:12]};
    endcase
  end

  // quotient never exceeds operand / divisor, so qb fits in 32 bits
  assign qb      = 33'(quo_r) * 33'(s2cd_pkg::div_base(cmd.div_sel));
  assign rem_nxt = rem_r - qb[31:0];

  assign leap = ((m4_r == 2'd0) && (m100_r != 7'd0)) || (m400_r == 9'd0);
  assign ylen = leap ? 9'd366 : 9'd365;

  // 365 = 1 mod 7, 366 = 2 mod 7
  assign wsum     = {1'b0, wacc_r} + (leap ? 4'd2 : 4'd1);
  assign wacc_nxt = (wsum >= 4'd7) ? 3'(wsum - 4'd7) : wsum[2:0];

  assign bound = s2cd_pkg::days_before(leap, mon_r);
  assign prev  = s2cd_pkg::days_before(leap, mon_r - 4'd1);

  assign sts.year_done = left_r < {7'd0, ylen};
  assign sts.month_hit = left_r < {7'd0, bound};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_r  <= in_epoch_seconds;
      year_r <= s2cd_pkg::EPOCH_YEAR;
      m4_r   <= 2'd2;
      m100_r <= 7'd70;
      m400_r <= 9'd370;
      wacc_r <= s2cd_pkg::EPOCH_WDAY;
      mon_r  <= 4'd1;
    end
    if (cmd.div_quo) begin
      quo_r <= quo_nxt;
      case (cmd.div_sel)
        s2cd_pkg::DIV_DAY:  left_r <= quo_nxt;
        s2cd_pkg::DIV_HOUR: hour_r <= quo_nxt[4:0];
        s2cd_pkg::DIV_MIN:  min_r  <= quo_nxt[5:0];
        default: ;
      endcase
    end
    if (cmd.div_rem) begin
      rem_r <= rem_nxt;
      case (cmd.div_sel)
        s2cd_pkg::DIV_MIN:  sec_r  <= rem_nxt[5:0];
        s2cd_pkg::DIV_WEEK: wday_r <= rem_nxt[2:0];
        default: ;
      endcase
    end
    if (cmd.year_step) begin
      left_r <= left_r - {7'd0, ylen};
      year_r <= year_r + 12'd1;
      m4_r   <= m4_r + 2'd1;
      m100_r <= (m100_r == 7'd99) ? 7'd0 : m100_r + 7'd1;
      m400_r <= (m400_r == 9'd399) ? 9'd0 : m400_r + 9'd1;
      wacc_r <= wacc_nxt;
    end
    if (cmd.month_step) begin
      if (sts.month_hit) begin
        mday_r <= 5'(left_r - {7'd0, prev} + 16'd1);
        // day of year plus weekday of Jan 1, reduced mod 7 next
        rem_r  <= 32'(left_r) + 32'(wacc_r);
      end else begin
        mon_r <= mon_r + 4'd1;
      end
    end
    if (cmd.out_load) begin
      out_year         <= year_r;
      out_month        <= mon_r;
      out_day_of_month <= mday_r;
      out_hour         <= hour_r;
      out_minute       <= min_r;
      out_second       <= sec_r;
      out_weekday      <= wday_r;
    end
  end

endmodule

[src/s2cd_ctrl.sv]
// ----------------------------------------------------------------------------
// s2cd_ctrl
// Sequencer: steps the datapath through divide, year, month and weekday
// phases and owns both handshakes.
// ----------------------------------------------------------------------------
module s2cd_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  s2cd_pkg::sts_t   sts,
  output s2cd_pkg::cmd_t   cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DAY   = 3'd1;
  localparam logic [2:0] ST_HOUR  = 3'd2;
  localparam logic [2:0] ST_MIN   = 3'd3;
  localparam logic [2:0] ST_YEAR  = 3'd4;
  localparam logic [2:0] ST_MONTH = 3'd5;
  localparam logic [2:0] ST_WEEK  = 3'd6;
  localparam logic [2:0] ST_FIN   = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       phase_r, phase_nxt;   // 0: quotient step, 1: remainder step
  logic       ovld_r, ovld_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = ovld_r;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    ovld_nxt  = ovld_r & ~out_ready;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DAY;
          phase_nxt = 1'b0;
        end
      end
      ST_DAY: begin
        cmd.div_sel = s2cd_pkg::DIV_DAY;
        if (!phase_r) begin
          cmd.div_quo = 1'b1;
          phase_nxt   = 1'b1;
        end else begin
          cmd.div_rem = 1'b1;
          phase_nxt   = 1'b0;
          state_nxt   = ST_HOUR;
        end
      end
      ST_HOUR: begin
        cmd.div_sel = s2cd_pkg::DIV_HOUR;
        if (!phase_r) begin
          cmd.div_quo = 1'b1;
          phase_nxt   = 1'b1;
        end else begin
          cmd.div_rem = 1'b1;
          phase_nxt   = 1'b0;
          state_nxt   = ST_MIN;
        end
      end
      ST_MIN: begin
        cmd.div_sel = s2cd_pkg::DIV_MIN;
        if (!phase_r) begin
          cmd.div_quo = 1'b1;
          phase_nxt   = 1'b1;
        end else begin
          cmd.div_rem = 1'b1;
          phase_nxt   = 1'b0;
          state_nxt   = ST_YEAR;
        end
      end
      ST_YEAR: begin
        if (sts.year_done) begin
          state_nxt = ST_MONTH;
        end else begin
          cmd.year_step = 1'b1;
        end
      end
      ST_MONTH: begin
        cmd.month_step = 1'b1;
        if (sts.month_hit) begin
          state_nxt = ST_WEEK;
          phase_nxt = 1'b0;
        end
      end
      ST_WEEK: begin
        cmd.div_sel = s2cd_pkg::DIV_WEEK;
        if (!phase_r) begin
          cmd.div_quo = 1'b1;
          phase_nxt   = 1'b1;
        end else begin
          cmd.div_rem = 1'b1;
          phase_nxt   = 1'b0;
          state_nxt   = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!ovld_r || out_ready) begin
          cmd.out_load = 1'b1;
          ovld_nxt     = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= 1'b0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

endmodule

[verif/seconds_to_calendar_date_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// seconds_to_calendar_date_tb
// Self-checking bench for the epoch-seconds to calendar date converter.
// ----------------------------------------------------------------------------
// Feeds 32-bit second counts through the valid/ready input channel and checks
// every output word against a behavioral calendar computed in the bench. A
// directed set covers the range ends, day, hour and minute edges, year ends,
// leap days with and without the century rule, and dates where the weekday
// sum goes negative. The random part mixes full-range words with words placed
// close to year, month and day boundaries. Both channels idle at random, with
// one long stretch at full rate.
// ----------------------------------------------------------------------------
module seconds_to_calendar_date_tb;

  localparam int unsigned CLK_HALF      = 5;
  localparam int unsigned RANDOM_WORDS  = 1528;
  localparam int unsigned STEADY_FIRST  = 500;   // no idling on either side
  localparam int unsigned STEADY_LAST   = 800;   // from here on, idling again
  localparam int unsigned DRAIN_CYCLES  = 200;   // longer than the slowest conversion
  localparam int unsigned STALL_LIMIT   = 3000;  // cycles with no handshake

  // one expected result word, tagged with the input that caused it
  typedef struct packed {
    logic [31:0] secs;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  mday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  wday;
  } date_word_t;

  // --------------------------------------------------------------------------
  // Scoreboard: calendar math plus the queue of dates still owed by the DUT.
  // --------------------------------------------------------------------------
  class calendar_scoreboard;
    date_word_t  owed_dates[$];
    int unsigned mismatches;
    int unsigned words_checked;
    int unsigned leap_days;
    int unsigned year_lo;
    int unsigned year_hi;
    // days before each month, common year then leap year
    int unsigned month_edge[2][13] = '{
      '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365},
      '{0, 31, 60, 91, 121, 152, 182, 213, 244, 274, 305, 335, 366}
    };

    function new();
      year_lo = 4095;
      year_hi = 0;
    endfunction

    function bit is_leap(int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function int unsigned year_days(int unsigned y);
      return is_leap(y) ? 366 : 365;
    endfunction

    // seconds at 00:00:00 on the first of month m (1..12) of year y
    function longint unsigned month_start(int unsigned y, int unsigned m);
      longint unsigned days;
      days = 0;
      for (int unsigned yy = 1970; yy < y; yy++) begin
        days += year_days(yy);
      end
      days += month_edge[is_leap(y)][m - 1];
      return days * 86400;
    endfunction

    function date_word_t to_calendar(logic [31:0] secs);
      date_word_t  d;
      int unsigned days_left, in_day, yr, mon, mday;
      bit          lp, found;
      int          zy, zm, cent, yoc, w;
      in_day    = secs % 86400;
      days_left = secs / 86400;
      yr        = 1970;
      while (days_left >= year_days(yr)) begin
        days_left -= year_days(yr);
        yr++;
      end
      lp    = is_leap(yr);
      mon   = 12;
      mday  = 1;
      found = 1'b0;
      for (int i = 1; i < 13; i++) begin
        if (!found && days_left < month_edge[lp][i]) begin
          mon   = i;
          mday  = days_left - month_edge[lp][i - 1] + 1;
          found = 1'b1;
        end
      end
      // Zeller: Jan and Feb count as months 13 and 14 of the year before
      zy = int'(yr);
      zm = int'(mon);
      if (zm <= 2) begin
        zm += 12;
        zy -= 1;
      end
      cent = zy / 100;
      yoc  = zy % 100;
      w = cent / 4 - 2 * cent + yoc + yoc / 4 + (26 * (zm + 1)) / 10 + int'(mday) - 1;
      w = w % 7;
      if (w < 0) begin
        w += 7;   // true modulo for negative sums
      end
      d.secs   = secs;
      d.year   = yr[11:0];
      d.month  = mon[3:0];
      d.mday   = mday[4:0];
      d.hour   = 5'(in_day / 3600);
      d.minute = 6'((in_day % 3600) / 60);
      d.second = 6'(in_day % 60);
      d.wday   = 3'(w);
      return d;
    endfunction

    function void note_input(logic [31:0] secs);
      owed_dates.push_back(to_calendar(secs));
    endfunction

    function void report(string msg);
      $display("[%0t] MISMATCH %s", $time, msg);
      mismatches++;
    endfunction

    function void cmp(string field, int unsigned got, int unsigned want, logic [31:0] secs);
      if (got != want) begin
        report($sformatf("%s: got %0d want %0d (secs %0d)", field, got, want, secs));
      end
    endfunction

    function void check_word(logic [11:0] year, logic [3:0] month, logic [4:0] mday,
                             logic [4:0] hour, logic [5:0] minute, logic [5:0] second,
                             logic [2:0] wday);
      date_word_t want;
      if (owed_dates.size() == 0) begin
        report($sformatf("unexpected word %0d-%0d-%0d %0d:%0d:%0d wd %0d",
                         year, month, mday, hour, minute, second, wday));
        return;
      end
      want = owed_dates.pop_front();
      cmp("year",   year,   want.year,   want.secs);
      cmp("month",  month,  want.month,  want.secs);
      cmp("mday",   mday,   want.mday,   want.secs);
      cmp("hour",   hour,   want.hour,   want.secs);
      cmp("minute", minute, want.minute, want.secs);
      cmp("second", second, want.second, want.secs);
      cmp("wday",   wday,   want.wday,   want.secs);
      words_checked++;
      if (want.month == 2 && want.mday == 29) begin
        leap_days++;
      end
      if (want.year < year_lo) year_lo = want.year;
      if (want.year > year_hi) year_hi = want.year;
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and its signals
  // --------------------------------------------------------------------------
  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_epoch_seconds;
  logic        out_valid;
  logic        out_ready;
  logic [11:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day_of_month;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [5:0]  out_second;
  logic [2:0]  out_weekday;

  seconds_to_calendar_date dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_epoch_seconds (in_epoch_seconds),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_year         (out_year),
    .out_month        (out_month),
    .out_day_of_month (out_day_of_month),
    .out_hour         (out_hour),
    .out_minute       (out_minute),
    .out_second       (out_second),
    .out_weekday      (out_weekday)
  );

  calendar_scoreboard sb = new();

  bit          steady = 1'b0;    // set during the full-rate stretch
  int unsigned stall_left = 0;   // remaining cycles of a long receiver stall
  int unsigned quiet_cycles = 0; // cycles since the last handshake

  // Directed words. Notes on the less obvious ones:
  //   1972-02-29 and 2000-02-29 are leap days; 2000 passes by the 400 rule.
  //   2000-03-01 and 2100-03-01 drive the weekday sum negative.
  //   2100-02-28 23:59:59 -> 2100-03-01: century year that is not leap.
  //   0x7FFFFFFF/0x80000000 straddle the signed 32-bit rollover.
  logic [31:0] corner_secs [22] = '{
    32'd0, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
    32'd31535999,            // 1970-12-31 23:59:59
    32'd31536000,            // 1971-01-01
    32'd68169600,            // 1972-02-29
    32'd94694399,            // 1972-12-31 23:59:59
    32'd946684799, 32'd946684800,
    32'd951782400,           // 2000-02-29
    32'd951868800,           // 2000-03-01
    32'd2147483647, 32'd2147483648,
    32'd4107542399, 32'd4107542400,
    32'hAAAA_AAAA, 32'h5555_5555,
    32'hFFFF_FFFF            // 2106-02-07 06:28:15, top of range
  };

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  always #(CLK_HALF) clk = ~clk;

  // --------------------------------------------------------------------------
  // Result side: ready changes on the falling edge. Mostly short random
  // stalls, now and then a long one so that a finished word sits in the
  // output register while the next conversion runs behind it.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready = 1'b0;
    end else if (stall_left != 0) begin
      out_ready  = 1'b0;
      stall_left = stall_left - 1;
    end else if (steady) begin
      out_ready = 1'b1;
    end else if ($urandom_range(999) < 2) begin
      out_ready  = 1'b0;
      stall_left = $urandom_range(50, 250);
    end else begin
      out_ready = ($urandom_range(99) >= 30);
    end
  end

  // results are taken at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_word(out_year, out_month, out_day_of_month, out_hour, out_minute,
                    out_second, out_weekday);
    end
  end

  // watchdog: any handshake restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[%0t] watchdog: no handshake in %0d cycles", $time, STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // Entered and left on a falling edge. Valid stays high into the next word
  // unless a gap is drawn.
  task automatic send_word(input logic [31:0] secs);
    in_epoch_seconds = secs;
    in_valid         = 1'b1;
    do begin
      @(posedge clk);
    end while (!in_ready);
    sb.note_input(secs);
    @(negedge clk);
    if (!steady && $urandom_range(99) < 30) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  // Random word: full range, or close to a year start, a month start or a
  // midnight, or near either end of the range.
  function automatic logic [31:0] random_secs();
    longint      base;
    int unsigned y;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom();
      4, 5: begin
        y    = $urandom_range(1971, 2106);
        base = longint'(sb.month_start(y, 1));
      end
      6, 7: begin
        y    = $urandom_range(1970, 2106);
        base = longint'(sb.month_start(y, $urandom_range(1, 12)));
      end
      8: base = longint'($urandom() / 86400) * 86400;
      default: begin
        if ($urandom_range(1) == 1) begin
          return 32'hFFFF_FFFF - $urandom_range(0, 40000000);
        end
        return $urandom_range(0, 40000000);
      end
    endcase
    // within an hour either side; wraps harmlessly past the range ends
    base = base + longint'($urandom_range(0, 7200)) - 3600;
    return base[31:0];
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    date_word_t lost;
    clk              = 1'b0;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_epoch_seconds = '0;
    out_ready        = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (corner_secs[i]) begin
      send_word(corner_secs[i]);
    end
    for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
      steady = (n >= STEADY_FIRST) && (n < STEADY_LAST);
      send_word(random_secs());
    end
    steady   = 1'b0;
    in_valid = 1'b0;

    // drain, then give the block time to show any stray word
    while (sb.owed_dates.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (sb.owed_dates.size() != 0) begin
      lost = sb.owed_dates.pop_front();
      sb.report($sformatf("no result for secs %0d", lost.secs));
    end

    $display("Checked %0d dates spanning years %0d..%0d, %0d of them leap days.",
             sb.words_checked, sb.year_lo, sb.year_hi, sb.leap_days);
    $display("Field mismatches and stray or missing words: %0d.", sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[seconds_to_calendar_date.f]
src/s2cd_pkg.sv
src/s2cd_dp.sv
src/s2cd_ctrl.sv
src/seconds_to_calendar_date.sv
verif/seconds_to_calendar_date_tb.sv
